FILE: rtl/scc_pkg.sv
// Shared types and constants for the stack calculator core.
// Used by scc_alu and stack_calculator_core_unit; no dependencies.
`timescale 1ns / 1ps

package scc_pkg;

    localparam int WORD_W  = 32;
    localparam int CNT_W   = $clog2(WORD_W);
    localparam int DEPTH_W = 9;
    localparam int OPC_W   = 3;

    // Instruction opcodes
    localparam logic [OPC_W-1:0] OP_PUSH = 3'd0;
    localparam logic [OPC_W-1:0] OP_ADD  = 3'd1;
    localparam logic [OPC_W-1:0] OP_MUL  = 3'd2;
    localparam logic [OPC_W-1:0] OP_DIV  = 3'd3;
    localparam logic [OPC_W-1:0] OP_END  = 3'd4;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_DIVZERO  = 2'd2,
        ST_HALTED   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        ALU_ADD = 2'd0,
        ALU_MUL = 2'd1,
        ALU_DIV = 2'd2
    } t_alu_op;

    typedef enum logic [1:0] {
        AS_IDLE = 2'd0,
        AS_RUN  = 2'd1,
        AS_FIN  = 2'd2
    } t_alu_state;

    typedef enum logic [2:0] {
        CS_IDLE = 3'd0,
        CS_READ = 3'd1,
        CS_WAIT = 3'd2,
        CS_DONE = 3'd3
    } t_ctl_state;

    typedef struct packed {
        logic             start;
        t_alu_op          op;
    } t_alu_ctl;

    typedef struct packed {
        logic [OPC_W-1:0]         opcode;
        logic signed [WORD_W-1:0] push_value;
    } t_in_word;

    typedef struct packed {
        logic signed [WORD_W-1:0] top_value;
        logic [DEPTH_W-1:0]       stack_depth;
        logic [1:0]               status;
    } t_out_word;

endpackage

FILE: rtl/stack_calculator_core_unit.sv
// Stack calculator core: top level with control sequencer and output register.
// Depends on scc_pkg, scc_ram and scc_alu.
`timescale 1ns / 1ps

// One decoded instruction word in, one status word out per instruction. The top
// of stack lives in a register and the entries below it in a RAM, so PUSH, END,
// halted and degenerate cases go from the accept straight to the output load,
// while ADD, MUL and DIV with two or more entries pass through the accept, one
// RAM read for the second entry that also starts the serial ALU, 32 ALU steps
// (one bit of sum, product or quotient per cycle), the ALU finish and the output
// load. Divide by zero skips the ALU and goes from the RAM read to the output
// load. The next word is accepted once the previous result is placed in the
// output register, which can hold it while the output stalls.
// No clearing pass is needed after reset.
module stack_calculator_core_unit
    import scc_pkg::*;
#(
    parameter int STACK_DEPTH = 256
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    localparam int AW   = $clog2(STACK_DEPTH);
    localparam int SP_W = $clog2(STACK_DEPTH + 1);

    t_ctl_state        r_state, n_state;
    logic [SP_W-1:0]   r_sp, n_sp;
    logic              r_halted, n_halted;
    logic [WORD_W-1:0] r_top, n_top;
    t_status           r_status, n_status;
    t_alu_op           r_op, n_op;
    logic              r_out_valid, n_out_valid;
    t_out_word         r_out_word, n_out_word;

    logic              w_accept;
    logic              w_ram_we;
    logic              w_ram_re;
    logic [AW-1:0]     w_waddr;
    logic [AW-1:0]     w_raddr;
    logic [WORD_W-1:0] w_rdata;
    logic [SP_W-1:0]   w_sp_m1;
    logic [SP_W-1:0]   w_sp_m2;
    logic [DEPTH_W+SP_W-1:0] w_depth_ext;
    t_alu_ctl          w_alu_ctl;
    logic              w_alu_done;
    logic [WORD_W-1:0] w_alu_result;

    scc_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_waddr),
        .i_wdata (r_top),
        .i_re    (w_ram_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    scc_alu u_alu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_alu_ctl),
        .i_a      (r_top),
        .i_b      (w_rdata),
        .o_done   (w_alu_done),
        .o_result (w_alu_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= CS_IDLE;
            r_sp        <= '0;
            r_halted    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sp        <= n_sp;
            r_halted    <= n_halted;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top      <= n_top;
        r_status   <= n_status;
        r_op       <= n_op;
        r_out_word <= n_out_word;
    end

    assign o_in_stall  = (r_state != CS_IDLE);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_sp_m1     = r_sp - SP_W'(1);
    assign w_sp_m2     = r_sp - SP_W'(2);
    // RAM holds the entries below the top register
    assign w_waddr     = w_sp_m1[AW-1:0];
    assign w_raddr     = w_sp_m2[AW-1:0];
    assign w_depth_ext = {{DEPTH_W{1'b0}}, r_sp};
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    always_comb begin
        n_state     = r_state;
        n_sp        = r_sp;
        n_halted    = r_halted;
        n_top       = r_top;
        n_status    = r_status;
        n_op        = r_op;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_word  = r_out_word;
        w_ram_we    = 1'b0;
        w_ram_re    = 1'b0;
        w_alu_ctl   = '{start: 1'b0, op: r_op};
        unique case (r_state)
            CS_IDLE: begin
                if (w_accept) begin
                    n_status = ST_OK;
                    n_state  = CS_DONE;
                    if (r_halted) begin
                        n_status = ST_HALTED;
                    end else begin
                        unique case (i_in_word.opcode)
                            OP_PUSH: begin
                                if (r_sp == SP_W'(STACK_DEPTH)) begin
                                    n_status = ST_OVERFLOW;
                                end else begin
                                    w_ram_we = (r_sp != '0);
                                    n_top    = i_in_word.push_value;
                                    n_sp     = r_sp + SP_W'(1);
                                end
                            end
                            OP_ADD, OP_MUL, OP_DIV: begin
                                if (i_in_word.opcode == OP_ADD) begin
                                    n_op = ALU_ADD;
                                end else if (i_in_word.opcode == OP_MUL) begin
                                    n_op = ALU_MUL;
                                end else begin
                                    n_op = ALU_DIV;
                                end
                                if (r_sp >= SP_W'(2)) begin
                                    w_ram_re = 1'b1;
                                    n_state  = CS_READ;
                                end else if (r_sp == SP_W'(1)) begin
                                    // lone entry: add keeps it, mul/div zero it
                                    if (i_in_word.opcode != OP_ADD) begin
                                        n_top = '0;
                                    end
                                end else begin
                                    n_top = '0;
                                    n_sp  = SP_W'(1);
                                end
                            end
                            OP_END: begin
                                n_halted = 1'b1;
                                n_status = ST_HALTED;
                            end
                            default: begin
                                n_status = ST_OK;
                            end
                        endcase
                    end
                end
            end
            CS_READ: begin
                if (r_op == ALU_DIV && w_rdata == '0) begin
                    n_top    = '0;
                    n_sp     = w_sp_m1;
                    n_status = ST_DIVZERO;
                    n_state  = CS_DONE;
                end else begin
                    w_alu_ctl.start = 1'b1;
                    n_state         = CS_WAIT;
                end
            end
            CS_WAIT: begin
                if (w_alu_done) begin
                    n_top   = w_alu_result;
                    n_sp    = w_sp_m1;
                    n_state = CS_DONE;
                end
            end
            CS_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid            = 1'b1;
                    n_out_word.top_value   = (r_sp == '0) ? '0 : r_top;
                    n_out_word.stack_depth = w_depth_ext[DEPTH_W-1:0];
                    n_out_word.status      = r_status;
                    n_state                = CS_IDLE;
                end
            end
            default: begin
                n_state = CS_IDLE;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_sp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= SP_W'(STACK_DEPTH))
        else $error("stack pointer beyond depth");

    a_accept_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_in_stall)
        else $error("input not stalled after accept");

    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |=> r_halted)
        else $error("halt flag cleared without reset");

    a_alu_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_alu_done |-> (r_state == CS_WAIT))
        else $error("ALU finished outside wait state");

    a_read_needs_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == CS_READ) |-> (r_sp >= SP_W'(2)))
        else $error("operand read with fewer than two entries");
`endif

endmodule

FILE: rtl/scc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module scc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/scc_alu.sv
// Serial arithmetic unit: bit-serial add, shift-add multiply, restoring divide.
// Depends on scc_pkg.
`timescale 1ns / 1ps

module scc_alu
    import scc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_alu_ctl          i_ctl,
    input  logic [WORD_W-1:0] i_a,
    input  logic [WORD_W-1:0] i_b,
    output logic              o_done,
    output logic [WORD_W-1:0] o_result
);

    t_alu_state        r_state, n_state;
    t_alu_op           r_op, n_op;
    logic [WORD_W-1:0] r_a, n_a;
    logic [WORD_W-1:0] r_b, n_b;
    logic [WORD_W:0]   r_acc, n_acc;
    logic              r_carry, n_carry;
    logic              r_neg, n_neg;
    logic [CNT_W-1:0]  r_cnt, n_cnt;

    logic              w_sum;
    logic [WORD_W:0]   w_rem_sh;
    logic [WORD_W:0]   w_diff;
    logic [WORD_W-1:0] w_abs_a;
    logic [WORD_W-1:0] w_abs_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= AS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_a     <= n_a;
        r_b     <= n_b;
        r_acc   <= n_acc;
        r_carry <= n_carry;
        r_neg   <= n_neg;
        r_cnt   <= n_cnt;
    end

    assign w_abs_a  = i_a[WORD_W-1] ? (~i_a + 1'b1) : i_a;
    assign w_abs_b  = i_b[WORD_W-1] ? (~i_b + 1'b1) : i_b;
    assign w_sum    = r_a[0] ^ r_b[0] ^ r_carry;
    assign w_rem_sh = {r_acc[WORD_W-1:0], r_a[WORD_W-1]};
    assign w_diff   = w_rem_sh - {1'b0, r_b};

    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_a      = r_a;
        n_b      = r_b;
        n_acc    = r_acc;
        n_carry  = r_carry;
        n_neg    = r_neg;
        n_cnt    = r_cnt;
        o_done   = 1'b0;
        o_result = r_acc[WORD_W-1:0];
        unique case (r_state)
            AS_IDLE: begin
                if (i_ctl.start) begin
                    n_op    = i_ctl.op;
                    n_acc   = '0;
                    n_carry = 1'b0;
                    n_cnt   = CNT_W'(WORD_W - 1);
                    n_neg   = i_a[WORD_W-1] ^ i_b[WORD_W-1];
                    // divide works on magnitudes, sign fixed at the end
                    if (i_ctl.op == ALU_DIV) begin
                        n_a = w_abs_a;
                        n_b = w_abs_b;
                    end else begin
                        n_a = i_a;
                        n_b = i_b;
                    end
                    n_state = AS_RUN;
                end
            end
            AS_RUN: begin
                unique case (r_op)
                    ALU_ADD: begin
                        n_acc   = {1'b0, w_sum, r_acc[WORD_W-1:1]};
                        n_carry = (r_a[0] & r_b[0]) | (r_carry & (r_a[0] ^ r_b[0]));
                        n_a     = {1'b0, r_a[WORD_W-1:1]};
                        n_b     = {1'b0, r_b[WORD_W-1:1]};
                    end
                    ALU_MUL: begin
                        n_acc = {1'b0, {r_acc[WORD_W-2:0], 1'b0}
                                 + (r_b[WORD_W-1] ? r_a : '0)};
                        n_b   = {r_b[WORD_W-2:0], 1'b0};
                    end
                    ALU_DIV: begin
                        if (!w_diff[WORD_W]) begin
                            n_acc = w_diff;
                            n_a   = {r_a[WORD_W-2:0], 1'b1};
                        end else begin
                            n_acc = w_rem_sh;
                            n_a   = {r_a[WORD_W-2:0], 1'b0};
                        end
                    end
                    default: begin
                        n_acc = r_acc;
                    end
                endcase
                if (r_cnt == '0) begin
                    n_state = AS_FIN;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            AS_FIN: begin
                o_done = 1'b1;
                if (r_op == ALU_DIV) begin
                    o_result = r_neg ? (~r_a + 1'b1) : r_a;
                end
                n_state = AS_IDLE;
            end
            default: begin
                n_state = AS_IDLE;
            end
        endcase
    end

endmodule
